// File: rtl/core/rsd_pkg.sv
// Shared types and character constants for the radix digit formatter.
package rsd_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_IDX_W = 4;
  localparam int COUNT_W    = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  typedef logic [7:0] symbol_t;
  typedef symbol_t [SLOT_COUNT-1:0] symbol_table_t;

  localparam symbol_t CHAR_PLUS  = 8'd43;
  localparam symbol_t CHAR_MINUS = 8'd45;
  localparam symbol_t PRINT_LOW  = 8'd32;
  localparam symbol_t PRINT_HIGH = 8'd126;

  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd2;

endpackage

// File: rtl/core/rsd_alpha_check.sv
// Alphabet validity check: count range, printable range, no signs, no repeats.
module rsd_alpha_check import rsd_pkg::*; #(
  parameter int MAX_SYMBOLS = 16
) (
  input  symbol_table_t      symbols,
  input  logic [COUNT_W-1:0] count,
  output logic               ok
);

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SYMBOLS);

  always_comb begin
    ok = (count >= COUNT_W'(2)) && (count <= MAX_COUNT);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (COUNT_W'(i) < count) begin
        if (symbols[i] < PRINT_LOW || symbols[i] > PRINT_HIGH ||
            symbols[i] == CHAR_PLUS || symbols[i] == CHAR_MINUS) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < SLOT_COUNT; j++) begin
          if (COUNT_W'(j) < count && symbols[j] == symbols[i]) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/rsd_divider.sv
// Iterative divide-by-radix unit: eight quotient bits per cycle, restoring.
module rsd_divider import rsd_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int DIGIT_W    = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIGIT_W:0]      radix,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIGIT_W-1:0]    remainder
);

  localparam int STEP_BITS = 8;
  localparam int NSTEP     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS  = NSTEP * STEP_BITS;
  localparam int CNT_W     = $clog2(NSTEP + 1);

  logic [PAD_BITS-1:0] work;
  logic [PAD_BITS-1:0] work_next;
  logic [DIGIT_W-1:0]  rem;
  logic [DIGIT_W-1:0]  rem_next;
  logic [CNT_W-1:0]    cnt;

  // One cycle's worth of long division: bring down a bit, subtract if it fits.
  always_comb begin
    logic [DIGIT_W:0] part;
    work_next = work;
    rem_next  = rem;
    for (int k = 0; k < STEP_BITS; k++) begin
      part      = {rem_next, work_next[PAD_BITS-1]};
      work_next = {work_next[PAD_BITS-2:0], 1'b0};
      if (part >= radix) begin
        rem_next     = DIGIT_W'(part - radix);
        work_next[0] = 1'b1;
      end else begin
        rem_next = part[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NSTEP);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= PAD_BITS'(dividend);
      rem  <= '0;
    end else if (cnt != '0) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work[VALUE_BITS-1:0];
  assign remainder = rem;

endmodule

// File: rtl/core/signed_integer_to_radix_digits.sv
// Flow: each digit takes one pass of the shared divide-by-radix unit (8 quotient bits a cycle),
//   after which the first beat is loaded into the output register.
// Throughput: one number at a time; for 32-bit values at most 32 digits,
//   then one beat per character; the next number is taken the cycle after the last beat.
// A rejected alphabet drops the item at once with no beats; ready stays high.
// Reset: synchronous active-high rst clears control and all configuration registers to zero.
module signed_integer_to_radix_digits import rsd_pkg::*; #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  // output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  last
);

  localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
  localparam int STACK_W = VALUE_BITS * DIGIT_W;
  localparam int ND_W    = $clog2(VALUE_BITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;
  logic [COUNT_W-1:0]    symbol_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= '0;
      symbols_high <= '0;
      symbol_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        REG_SYMBOL_COUNT: symbol_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Slots 0..7 from the low word, 8..15 from the high word, lowest byte first.
  symbol_table_t sym_table;
  always_comb begin
    for (int i = 0; i < SLOT_COUNT / 2; i++) begin
      sym_table[i]                  = symbols_low[8*i +: 8];
      sym_table[i + SLOT_COUNT / 2] = symbols_high[8*i +: 8];
    end
  end

  logic alpha_ok;

  rsd_alpha_check #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_check (
    .symbols(sym_table),
    .count  (symbol_count),
    .ok     (alpha_ok)
  );

  // Control and digit stack.
  logic [1:0]            state;
  logic                  sign_pend;
  logic [ND_W-1:0]       nd;
  logic [STACK_W-1:0]    stack;

  logic                  in_beat;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  logic [VALUE_BITS-1:0] magnitude;
  logic                  negative;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;

  // Two's complement magnitude; the most negative value yields 2^(VALUE_BITS-1) unsigned.
  assign negative  = value[VALUE_BITS-1];
  assign magnitude = negative ? (~value + 1'b1) : value;

  // Kick the divider on a good input beat, and again on each nonzero quotient.
  assign div_start    = (in_beat && alpha_ok) ||
                        (state == S_DIV && div_done && div_quot != '0);
  assign div_dividend = (state == S_IDLE) ? magnitude : div_quot;

  rsd_divider #(
    .VALUE_BITS(VALUE_BITS),
    .DIGIT_W   (DIGIT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (symbol_count[DIGIT_W:0]),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sign_pend <= 1'b0;
      nd        <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // Drop the item outright when the alphabet is bad.
          if (in_beat && alpha_ok) begin
            state     <= S_DIV;
            sign_pend <= negative;
            nd        <= '0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            nd <= nd + 1'b1;
            if (div_quot == '0) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          // Advance when the output register is empty or its beat leaves now.
          if (!out_valid || out_ready) begin
            if (sign_pend) begin
              out_valid <= 1'b1;
              sign_pend <= 1'b0;
            end else if (nd != '0) begin
              out_valid <= 1'b1;
              nd        <= nd - 1'b1;
            end else begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload: push remainders on the low end (most significant lands on top), pop from there.
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      stack <= {stack[STACK_W-DIGIT_W-1:0], div_rem};
    end
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      if (sign_pend) begin
        out_char <= CHAR_MINUS;
        last     <= 1'b0;
      end else if (nd != '0) begin
        out_char <= sym_table[SLOT_IDX_W'(stack[DIGIT_W-1:0])];
        last     <= (nd == ND_W'(1));
        stack    <= stack >> DIGIT_W;
      end
    end
  end

endmodule
